[rtl/itoa_pkg.sv]
// package with payload types, sequencer states and character constants
package itoa_pkg;

  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_MINUS   = 8'h2D;
  localparam logic [5:0] DECIMAL_RADIX = 6'd10;
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;
  localparam int DIGIT_W = 6;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [5:0]  radix;
    logic        uppercase;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_last;
    logic [6:0] char_count;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PREP,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] base;
    if (d < DECIMAL_RADIX) begin
      digit_char = CHR_ZERO + {2'b00, d};
    end else begin
      base = upper ? CHR_UPPER_A : CHR_LOWER_A;
      digit_char = base + {2'b00, d - DECIMAL_RADIX};
    end
  endfunction

endpackage

[rtl/integer_to_ascii_digits.sv]
// top level: radix conversion of a 64-bit value into a stream of ascii characters
//
// in channel: in_valid / in_ready carry one number (value, radix, uppercase flag).
// out channel: out_valid / out_ready carry one character per transfer, most
// significant digit first, with a leading minus for negative decimal values.
// every character carries the total character count; the final one has is_last.
// radix below 2 is taken as 2, above 36 as 36; decimal values are signed.
// each digit takes one pass of the shared bit-serial divider, which runs 64
// iterations per pass. after the digits are found, each digit character goes
// through a ram read, a load and a transfer, the transfer waiting while the
// receiver stalls; a prep state follows the last digit and loads the leading
// minus for a negative value, which is then sent first. one number at a time,
// in_ready high only idle.
// the output register holds its character while out_ready is low.
// synchronous reset returns the sequencer to idle; the digit ram is not cleared
// and needs no clearing pass, since every entry is written before it is read.
module integer_to_ascii_digits
  import itoa_pkg::*;
#(
  parameter int MAX_DIGITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t state, state_next;

  logic [63:0]   mag;
  logic [5:0]    radix_r;
  logic          upper;
  logic          neg;
  logic [CW-1:0] digits;
  logic [CW-1:0] digits_inc;
  logic [CW-1:0] rd_idx;
  logic [6:0]    total;
  logic          finish;
  out_t          out_reg;

  logic [5:0]    radix_cl;
  logic          in_neg;

  logic          div_start;
  logic [63:0]   div_quo;
  logic [5:0]    div_rem;
  div_sts_t      div_sts;
  logic          ram_we;
  logic          ram_re;
  logic [5:0]    ram_rdata;

  assign radix_cl = (in_data.radix < RADIX_MIN) ? RADIX_MIN :
                    (in_data.radix > RADIX_MAX) ? RADIX_MAX : in_data.radix;
  assign in_neg   = (radix_cl == DECIMAL_RADIX) && in_data.value_bits[63];

  assign digits_inc = digits + CW'(1);
  assign rd_idx     = digits - CW'(1);
  assign finish     = (div_quo == 64'd0) || (digits_inc == CW'(MAX_DIGITS));

  itoa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digits[AW-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DIV_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_sts.done) state_next = finish ? ST_PREP : ST_DIV_START;
      end
      ST_PREP: state_next = neg ? ST_SEND : ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SEND;
      ST_SEND: begin
        if (out_ready) state_next = out_reg.is_last ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (state)
      ST_IDLE:      in_ready  = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  ram_we    = div_sts.done;
      ST_READ:      ram_re    = 1'b1;
      ST_SEND:      out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      digits <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        digits <= '0;
      end else if (ram_we) begin
        digits <= digits_inc;
      end else if (state == ST_LOAD) begin
        digits <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag     <= in_neg ? (64'd0 - in_data.value_bits) : in_data.value_bits;
      radix_r <= radix_cl;
      upper   <= in_data.uppercase;
      neg     <= in_neg;
    end else if (ram_we) begin
      mag <= div_quo;
    end
    if (state == ST_PREP) begin
      total <= 7'(digits) + {6'd0, neg};
      out_reg.out_char   <= CHR_MINUS;
      out_reg.is_last    <= 1'b0;
      out_reg.char_count <= 7'(digits) + 7'd1;
    end else if (state == ST_LOAD) begin
      out_reg.out_char   <= digit_char(ram_rdata, upper);
      out_reg.is_last    <= (digits == CW'(1));
      out_reg.char_count <= total;
    end
  end

  assign out_data = out_reg;

  property p_last_to_idle;
    @(posedge clk) disable iff (rst)
      out_valid && out_ready && out_data.is_last |=> in_ready;
  endproperty
  a_last_to_idle: assert property (p_last_to_idle) else $error("not idle after last char");

  property p_accept_quiet;
    @(posedge clk) disable iff (rst) in_valid && in_ready |=> !out_valid && !in_ready;
  endproperty
  a_accept_quiet: assert property (p_accept_quiet) else $error("output right after accept");

  property p_digit_bound;
    @(posedge clk) disable iff (rst)
      ram_we |-> digits < CW'(MAX_DIGITS);
  endproperty
  a_digit_bound: assert property (p_digit_bound) else $error("digit store overrun");

endmodule

[rtl/itoa_ram.sv]
// generic single write port ram with registered read
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/itoa_div.sv]
// iterative restoring divider, 64-bit dividend by 6-bit radix, one bit per cycle
module itoa_div
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  dividend,
  input  logic [5:0]   divisor,
  output logic [63:0]  quotient,
  output logic [5:0]   remainder,
  output div_sts_t     sts
);

  logic [63:0] quo;
  logic [5:0]  rem;
  logic [5:0]  dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [6:0]  rem_sh;
  logic        ge;
  logic [6:0]  rem_sub;

  assign rem_sh  = {rem, quo[63]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[62:0], ge};
      rem <= ge ? rem_sub[5:0] : rem_sh[5:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign sts.busy  = busy;
  assign sts.done  = done;

  property p_start_busy;
    @(posedge clk) disable iff (rst) start |=> busy && !done;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("divider did not start");

endmodule

[dv/tb_integer_to_ascii_digits.sv]
// testbench for integer_to_ascii_digits: random and directed numbers checked char by char
`timescale 1ns / 100ps

module tb_integer_to_ascii_digits;
  import itoa_pkg::*;

  localparam int DIGIT_LIMIT      = 64;
  localparam int RANDOM_NUMBERS   = 210;
  localparam int CALM_LEFT        = 25;
  localparam int DRAIN_AT         = 120;
  localparam int LONG_HOLD_AT     = 40;
  localparam int LONG_HOLD_CYCLES = 2500;
  localparam int END_CYCLES       = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_numbers[$];
  out_t expected_chars[$];

  int   mismatch_count   = 0;
  int   numbers_accepted = 0;
  int   numbers_issued   = 0;
  int   gap_left         = 0;
  int   hold_left        = 0;
  bit   long_hold_done   = 1'b0;
  logic in_taken         = 1'b0;
  logic calm             = 1'b0;

  integer_to_ascii_digits #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] char_of_digit(input logic [5:0] d, input logic upper);
    if (d < DECIMAL_RADIX) begin
      return CHR_ZERO + {2'b00, d};
    end
    return (upper ? CHR_UPPER_A : CHR_LOWER_A) + {2'b00, d - DECIMAL_RADIX};
  endfunction

  function automatic void predict_number(input in_t item);
    logic [5:0]  base;
    logic [63:0] mag;
    logic [5:0]  digs [DIGIT_LIMIT];
    logic [6:0]  total;
    bit          neg;
    int          count;
    int          k;
    out_t        c;
    base = item.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    mag = item.value_bits;
    neg = 1'b0;
    if (base == DECIMAL_RADIX && mag[63]) begin
      neg = 1'b1;
      mag = 64'd0 - mag;
    end
    count = 0;
    if (mag == 64'd0) begin
      digs[0] = '0;
      count = 1;
    end else begin
      while (mag != 64'd0 && count < DIGIT_LIMIT) begin
        digs[count] = 6'(mag % {58'd0, base});
        mag = mag / {58'd0, base};
        count++;
      end
    end
    total = 7'(count + (neg ? 1 : 0));
    if (neg) begin
      c.out_char = CHR_MINUS;
      c.is_last = 1'b0;
      c.char_count = total;
      expected_chars.push_back(c);
    end
    for (k = count - 1; k >= 0; k--) begin
      c.out_char = char_of_digit(digs[k], item.uppercase);
      c.is_last = (k == 0);
      c.char_count = total;
      expected_chars.push_back(c);
    end
  endfunction

  task automatic add_number(input logic [63:0] value, input logic [5:0] radix,
                            input logic upper);
    in_t item;
    item.value_bits = value;
    item.radix = radix;
    item.uppercase = upper;
    pending_numbers.push_back(item);
  endtask

  function automatic in_t random_number();
    in_t item;
    int  pick;
    int  width;
    pick = $urandom_range(0, 99);
    item.value_bits = {$urandom, $urandom};
    width = $urandom_range(1, 20);
    if (pick < 60) begin
      item.value_bits = item.value_bits & ((64'd1 << width) - 64'd1);
    end else if (pick < 75) begin
      item.value_bits = 64'd0 - (item.value_bits & ((64'd1 << width) - 64'd1));
    end else if (pick < 90) begin
      item.value_bits = item.value_bits;
    end else begin
      case ($urandom_range(0, 5))
        0: item.value_bits = 64'd0;
        1: item.value_bits = {64{1'b1}};
        2: item.value_bits = 64'h8000_0000_0000_0000;
        3: item.value_bits = 64'h7FFF_FFFF_FFFF_FFFF;
        4: item.value_bits = 64'd1 << $urandom_range(0, 63);
        default: item.value_bits = 64'd1;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) item.radix = DECIMAL_RADIX;
    else if (pick < 85) item.radix = 6'($urandom_range(2, 36));
    else item.radix = 6'($urandom_range(0, 63));
    item.uppercase = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (numbers_issued == DRAIN_AT && expected_chars.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_numbers.size() != 0) begin
        in_data <= pending_numbers.pop_front();
        in_valid <= 1'b1;
        numbers_issued++;
        calm <= (pending_numbers.size() < CALM_LEFT);
        if (pending_numbers.size() >= CALM_LEFT && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 16);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && numbers_accepted >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on input transfer, check on output transfer
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_number(in_data);
        numbers_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transfer: out_char %02h is_last %0d char_count %0d",
                 out_data.out_char, out_data.is_last, out_data.char_count);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, out_data.out_char);
            mismatch_count++;
          end
          if (out_data.is_last !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, out_data.is_last);
            mismatch_count++;
          end
          if (out_data.char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count,
                   out_data.char_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int n;
    add_number(64'd0, DECIMAL_RADIX, 1'b0);
    add_number(64'd0, 6'd2, 1'b1);
    add_number(64'd1, 6'd2, 1'b0);
    add_number({64{1'b1}}, 6'd2, 1'b0);
    add_number(64'h8000_0000_0000_0000, 6'd2, 1'b1);
    add_number({64{1'b1}}, 6'd16, 1'b1);
    add_number({64{1'b1}}, 6'd16, 1'b0);
    add_number({64{1'b1}}, 6'd36, 1'b1);
    add_number({64{1'b1}}, 6'd36, 1'b0);
    add_number({64{1'b1}}, 6'd8, 1'b0);
    add_number(64'h8000_0000_0000_0000, DECIMAL_RADIX, 1'b0);
    add_number(64'h7FFF_FFFF_FFFF_FFFF, DECIMAL_RADIX, 1'b1);
    add_number({64{1'b1}}, DECIMAL_RADIX, 1'b0);
    add_number(64'd0 - 64'd1234567890, DECIMAL_RADIX, 1'b0);
    add_number(64'd9, DECIMAL_RADIX, 1'b0);
    add_number(64'd5, 6'd0, 1'b0);
    add_number(64'd5, 6'd1, 1'b1);
    add_number(64'd1295, 6'd37, 1'b1);
    add_number(64'hFFFF, 6'd63, 1'b0);
    add_number(64'd10, 6'd11, 1'b0);
    add_number(64'd35, 6'd36, 1'b1);
    add_number(64'd35, 6'd36, 1'b0);
    for (n = 0; n < RANDOM_NUMBERS; n++) begin
      pending_numbers.push_back(random_number());
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
rtl/itoa_pkg.sv
rtl/itoa_ram.sv
rtl/itoa_div.sv
rtl/integer_to_ascii_digits.sv
dv/tb_integer_to_ascii_digits.sv
